/* sv/wavhp_pkg.sv */
// ----------------------------------------------------------------------------
// wavhp_pkg
// Types, codes and header layout constants for the WAV header parser.
// ----------------------------------------------------------------------------
`default_nettype none

package wavhp_pkg;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       file_start;
    } in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  error_kind;
        logic [7:0]  payload_byte;
        logic        last_payload;
        logic        header_valid;
        logic [15:0] channels;
        logic [31:0] sample_rate;
        logic [15:0] sample_bits;
        logic [30:0] data_size;
        logic [30:0] sample_count;
    } out_t;

    // item status codes
    localparam logic [1:0] STAT_HEADER  = 2'd0;
    localparam logic [1:0] STAT_PAYLOAD = 2'd1;
    localparam logic [1:0] STAT_ERROR   = 2'd2;
    localparam logic [1:0] STAT_EXCESS  = 2'd3;

    // error codes
    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_RIFF       = 3'd1;
    localparam logic [2:0] ERR_WAVE       = 3'd2;
    localparam logic [2:0] ERR_FMT        = 3'd3;
    localparam logic [2:0] ERR_DATA       = 3'd4;
    localparam logic [2:0] ERR_BAD_SIZE   = 3'd5;
    localparam logic [2:0] ERR_ZERO_BLOCK = 3'd6;

    // header layout
    localparam logic [5:0] POS_CH      = 6'd22;
    localparam logic [5:0] POS_RATE    = 6'd24;
    localparam logic [5:0] POS_BITS    = 6'd34;
    localparam logic [5:0] POS_SIZE    = 6'd40;
    localparam logic [5:0] POS_LAST    = 6'd43;
    localparam logic [5:0] POS_PAYLOAD = 6'd44;

    localparam logic [31:0] TAG_RIFF = "RIFF";
    localparam logic [31:0] TAG_WAVE = "WAVE";
    localparam logic [31:0] TAG_FMT  = "fmt ";
    localparam logic [31:0] TAG_DATA = "data";

    localparam int DIV_STEPS = 31;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef struct packed {
        logic       is_tag;
        logic       first;
        logic       last;
        logic [7:0] ch;
        logic [2:0] kind;
    } tag_info_t;

    // controller -> datapath
    typedef struct packed {
        logic step;
        logic load_step;
        logic load_div;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic need_div;
        logic div_done;
    } sts_t;

    function automatic tag_info_t tag_info(input logic [5:0] pos);
        tag_info_t  t;
        logic [31:0] word;
        word   = TAG_RIFF;
        t.kind = ERR_NONE;
        t.is_tag = 1'b1;
        if (pos inside {[6'd0:6'd3]}) begin
            word   = TAG_RIFF;
            t.kind = ERR_RIFF;
        end else if (pos inside {[6'd8:6'd11]}) begin
            word   = TAG_WAVE;
            t.kind = ERR_WAVE;
        end else if (pos inside {[6'd12:6'd15]}) begin
            word   = TAG_FMT;
            t.kind = ERR_FMT;
        end else if (pos inside {[6'd36:6'd39]}) begin
            word   = TAG_DATA;
            t.kind = ERR_DATA;
        end else begin
            t.is_tag = 1'b0;
        end
        t.first = (pos[1:0] == 2'd0);
        t.last  = (pos[1:0] == 2'd3);
        case (pos[1:0])
            2'd0:    t.ch = word[31:24];
            2'd1:    t.ch = word[23:16];
            2'd2:    t.ch = word[15:8];
            default: t.ch = word[7:0];
        endcase
        return t;
    endfunction

endpackage

`default_nettype wire

/* sv/wavhp_divider.sv */
// ----------------------------------------------------------------------------
// wavhp_divider
// Restoring divider, one quotient bit per cycle, for the sample count.
// ----------------------------------------------------------------------------
`default_nettype none

module wavhp_divider (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [30:0] dividend,
    input  wire logic [31:0] divisor,
    output logic             done,
    output logic [30:0]      quotient
);

    localparam logic [wavhp_pkg::DIV_CNT_W-1:0] CNT_LAST =
        wavhp_pkg::DIV_CNT_W'(wavhp_pkg::DIV_STEPS - 1);

    logic                              busy_reg;
    logic                              done_reg;
    logic [wavhp_pkg::DIV_CNT_W-1:0]   cnt_reg;
    logic [31:0]                       rem_reg;
    logic [31:0]                       dvs_reg;
    logic [30:0]                       q_reg;
    logic [32:0]                       shifted;
    logic [32:0]                       diff;

    assign shifted = {rem_reg, q_reg[30]};
    assign diff    = shifted - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CNT_LAST);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dvs_reg <= divisor;
            q_reg   <= dividend;
        end
        else if (busy_reg)
        begin
            if (!diff[32])
            begin
                rem_reg <= diff[31:0];
                q_reg   <= {q_reg[29:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[31:0];
                q_reg   <= {q_reg[29:0], 1'b0};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

`default_nettype wire

/* sv/wavhp_datapath.sv */
// ----------------------------------------------------------------------------
// wavhp_datapath
// Header state, tag checks, field capture, payload count and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module wavhp_datapath (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire wavhp_pkg::in_t  item,
    input  wire wavhp_pkg::cmd_t cmd,
    output wavhp_pkg::sts_t      sts,
    output wavhp_pkg::out_t      result
);

    logic [5:0]  pos_reg,  pos_next;
    logic [2:0]  err_reg,  err_next;
    logic        tag_reg,  tag_next;
    logic        done_reg, done_next;
    logic [15:0] ch_reg,   ch_next;
    logic [31:0] rate_reg, rate_next;
    logic [15:0] bits_reg, bits_next;
    logic [31:0] size_reg, size_next;
    logic [30:0] samp_reg, samp_next;
    logic [30:0] left_reg, left_next;
    logic [31:0] block_reg;

    logic [5:0]  e_pos;
    logic [2:0]  e_err;
    logic        e_tag;
    logic        e_done;
    logic [15:0] e_ch;
    logic [31:0] e_rate;
    logic [15:0] e_bits;
    logic [31:0] e_size;
    logic [30:0] e_samp;
    logic [30:0] e_left;

    logic        f;
    logic [7:0]  b;
    logic        need_div;
    logic        div_done;
    logic [30:0] quot;
    wavhp_pkg::out_t step_res;
    wavhp_pkg::out_t div_res;
    wavhp_pkg::out_t out_reg;

    assign f = item.file_start;
    assign b = item.byte_in;

    assign e_pos  = f ? '0   : pos_reg;
    assign e_err  = f ? wavhp_pkg::ERR_NONE : err_reg;
    assign e_tag  = f ? 1'b1 : tag_reg;
    assign e_done = f ? 1'b0 : done_reg;
    assign e_ch   = f ? '0   : ch_reg;
    assign e_rate = f ? '0   : rate_reg;
    assign e_bits = f ? '0   : bits_reg;
    assign e_size = f ? '0   : size_reg;
    assign e_samp = f ? '0   : samp_reg;
    assign e_left = f ? '0   : left_reg;

    always_comb
    begin
        wavhp_pkg::tag_info_t tg;
        logic                 ok;
        logic                 stop;
        logic [5:0]           lane;
        tg        = wavhp_pkg::tag_info(e_pos);
        ok        = (tg.first | e_tag) & (b == tg.ch);
        stop      = 1'b0;
        lane      = '0;
        pos_next  = e_pos;
        err_next  = e_err;
        tag_next  = e_tag;
        done_next = e_done;
        ch_next   = e_ch;
        rate_next = e_rate;
        bits_next = e_bits;
        size_next = e_size;
        samp_next = e_samp;
        left_next = e_left;
        need_div  = 1'b0;
        step_res  = '0;
        step_res.status = wavhp_pkg::STAT_HEADER;

        if (e_err != wavhp_pkg::ERR_NONE)
        begin
            step_res.status = wavhp_pkg::STAT_ERROR;
        end
        else if (e_done)
        begin
            if (e_left != '0)
            begin
                step_res.status       = wavhp_pkg::STAT_PAYLOAD;
                step_res.payload_byte = b;
                step_res.last_payload = (e_left == 31'd1);
                left_next             = e_left - 31'd1;
            end
            else
            begin
                step_res.status = wavhp_pkg::STAT_EXCESS;
            end
        end
        else
        begin
            if (tg.is_tag)
            begin
                tag_next = ok;
                if (tg.last && !ok)
                begin
                    err_next = tg.kind;
                    stop     = 1'b1;
                end
            end
            else if (e_pos inside {[wavhp_pkg::POS_CH:wavhp_pkg::POS_CH + 6'd1]})
            begin
                lane = e_pos - wavhp_pkg::POS_CH;
                ch_next[{lane[0], 3'b000} +: 8] = ch_next[{lane[0], 3'b000} +: 8] | b;
            end
            else if (e_pos inside {[wavhp_pkg::POS_RATE:wavhp_pkg::POS_RATE + 6'd3]})
            begin
                lane = e_pos - wavhp_pkg::POS_RATE;
                rate_next[{lane[1:0], 3'b000} +: 8] =
                    rate_next[{lane[1:0], 3'b000} +: 8] | b;
            end
            else if (e_pos inside {[wavhp_pkg::POS_BITS:wavhp_pkg::POS_BITS + 6'd1]})
            begin
                lane = e_pos - wavhp_pkg::POS_BITS;
                bits_next[{lane[0], 3'b000} +: 8] = bits_next[{lane[0], 3'b000} +: 8] | b;
            end
            else if (e_pos inside {[wavhp_pkg::POS_SIZE:wavhp_pkg::POS_LAST]})
            begin
                lane = e_pos - wavhp_pkg::POS_SIZE;
                size_next[{lane[1:0], 3'b000} +: 8] =
                    size_next[{lane[1:0], 3'b000} +: 8] | b;
            end

            if (!stop)
            begin
                if (e_pos == wavhp_pkg::POS_LAST)
                begin
                    if (size_next == '0 || size_next[31])
                        err_next = wavhp_pkg::ERR_BAD_SIZE;
                    else if (block_reg == '0)
                        err_next = wavhp_pkg::ERR_ZERO_BLOCK;
                    else
                    begin
                        need_div  = 1'b1;
                        done_next = 1'b1;
                        left_next = size_next[30:0];
                        pos_next  = wavhp_pkg::POS_PAYLOAD;
                    end
                end
                else
                begin
                    pos_next = e_pos + 6'd1;
                end
            end

            if (err_next != wavhp_pkg::ERR_NONE)
                step_res.status = wavhp_pkg::STAT_ERROR;
        end

        if (step_res.status == wavhp_pkg::STAT_ERROR)
            step_res.error_kind = err_next;
        step_res.header_valid = done_next;
        if (done_next)
        begin
            step_res.channels     = ch_next;
            step_res.sample_rate  = rate_next;
            step_res.sample_bits  = bits_next;
            step_res.data_size    = size_next[30:0];
            step_res.sample_count = samp_next;
        end
    end

    always_comb
    begin
        div_res              = '0;
        div_res.status       = wavhp_pkg::STAT_HEADER;
        div_res.error_kind   = wavhp_pkg::ERR_NONE;
        div_res.header_valid = 1'b1;
        div_res.channels     = ch_reg;
        div_res.sample_rate  = rate_reg;
        div_res.sample_bits  = bits_reg;
        div_res.data_size    = size_reg[30:0];
        div_res.sample_count = quot;
    end

    wavhp_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.step && need_div),
        .dividend (size_next[30:0]),
        .divisor  (block_reg),
        .done     (div_done),
        .quotient (quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            err_reg  <= wavhp_pkg::ERR_NONE;
            tag_reg  <= 1'b1;
            done_reg <= 1'b0;
            ch_reg   <= '0;
            rate_reg <= '0;
            bits_reg <= '0;
            size_reg <= '0;
            samp_reg <= '0;
            left_reg <= '0;
        end
        else if (cmd.step)
        begin
            pos_reg  <= pos_next;
            err_reg  <= err_next;
            tag_reg  <= tag_next;
            done_reg <= done_next;
            ch_reg   <= ch_next;
            rate_reg <= rate_next;
            bits_reg <= bits_next;
            size_reg <= size_next;
            samp_reg <= samp_next;
            left_reg <= left_next;
        end
        else if (cmd.load_div)
        begin
            samp_reg <= quot;
        end
    end

    // block size; operands settle well before the last header byte
    always_ff @(posedge clk)
    begin
        block_reg <= (32'(ch_reg) * 32'(bits_reg)) >> 3;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_step)
            out_reg <= step_res;
        else if (cmd.load_div)
            out_reg <= div_res;
    end

    assign sts.need_div = need_div;
    assign sts.div_done = div_done;
    assign result       = out_reg;

endmodule

`default_nettype wire

/* sv/wavhp_ctrl.sv */
// ----------------------------------------------------------------------------
// wavhp_ctrl
// Handshake control: accepts items, waits on the divider, owns result valid.
// ----------------------------------------------------------------------------
`default_nettype none

module wavhp_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            item_valid,
    output logic                 item_ready,
    output logic                 result_valid,
    input  wire logic            result_ready,
    input  wire wavhp_pkg::sts_t sts,
    output wavhp_pkg::cmd_t      cmd
);

    localparam logic ST_RUN = 1'b0;
    localparam logic ST_DIV = 1'b1;

    logic state_reg, state_next;
    logic valid_reg, valid_next;
    logic acc;

    assign item_ready = (state_reg == ST_RUN) && (!valid_reg || result_ready);
    assign acc        = item_valid && item_ready;

    always_comb
    begin
        cmd.step      = acc;
        cmd.load_step = acc && !sts.need_div;
        cmd.load_div  = (state_reg == ST_DIV) && sts.div_done;

        state_next = state_reg;
        case (state_reg)
            ST_RUN:
                if (acc && sts.need_div)
                    state_next = ST_DIV;
            ST_DIV:
                if (sts.div_done)
                    state_next = ST_RUN;
            default:
                state_next = ST_RUN;
        endcase

        valid_next = valid_reg;
        if (cmd.load_step || cmd.load_div)
            valid_next = 1'b1;
        else if (result_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RUN;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    assign result_valid = valid_reg;

endmodule

`default_nettype wire

/* sv/wav_header_parser_unit.sv */
// ----------------------------------------------------------------------------
// wav_header_parser_unit
// Byte-stream WAV header parser: tag checks, field capture, payload framing.
// ----------------------------------------------------------------------------
// The result is registered when an item is accepted, or when the divider is done for the last header byte.
// Throughput: one item per cycle while no divide is running, limited by the result register.
// The last header byte, when its size and block size are valid, stalls the input
// while the serial divider computes the sample count, one quotient bit per cycle.
// Reset clears all parser state and drops any pending result.
`default_nettype none

module wav_header_parser_unit (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            item_valid,
    output logic                 item_ready,
    input  wire wavhp_pkg::in_t  item,
    output logic                 result_valid,
    input  wire logic            result_ready,
    output wavhp_pkg::out_t      result
);

    wavhp_pkg::cmd_t cmd;
    wavhp_pkg::sts_t sts;

    wavhp_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .sts          (sts),
        .cmd          (cmd)
    );

    wavhp_datapath u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .sts    (sts),
        .result (result)
    );

    a_div_stall: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && sts.need_div |=> !item_ready)
        else $error("input not stalled during divide");

    a_kind_match: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ((result.status == wavhp_pkg::STAT_ERROR) ==
                          (result.error_kind != wavhp_pkg::ERR_NONE)))
        else $error("error kind does not match status");

    a_payload_hdr: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.status == wavhp_pkg::STAT_PAYLOAD ||
                         result.status == wavhp_pkg::STAT_EXCESS)
        |-> result.header_valid)
        else $error("payload item without accepted header");

    a_last_payload: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.last_payload
        |-> result.status == wavhp_pkg::STAT_PAYLOAD)
        else $error("last flag on non-payload item");

endmodule

`default_nettype wire
